### src/efc_pkg.sv
// Shared types and constants for the coalescing event queue.
package efc_pkg;

  localparam int unsigned TopicCount = 8;
  localparam int unsigned SlotCount  = 3;

  typedef enum logic [1:0] {
    MODE_PUSH = 2'd0,
    MODE_POP  = 2'd1,
    MODE_SNAP = 2'd2,
    MODE_NONE = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_PUSH_CLEAN = 3'd0,
    ST_PUSH_DROP  = 3'd1,
    ST_POPPED     = 3'd2,
    ST_EMPTY      = 3'd3,
    ST_SNAP_DONE  = 3'd4
  } status_e;

  localparam logic [2:0] LogTopic = 3'd7;

  // Map a topic to its pending slot; SlotNone when it has none.
  localparam logic [1:0] SlotNone = 2'd3;

  function automatic logic [1:0] slot_of(input logic [2:0] t);
    logic [1:0] s;
    case (t)
      3'd1:    s = 2'd0;
      3'd2:    s = 2'd1;
      3'd5:    s = 2'd2;
      default: s = SlotNone;
    endcase
    return s;
  endfunction

  function automatic logic [2:0] slot_topic(input logic [1:0] s);
    logic [2:0] t;
    case (s)
      2'd0:    t = 3'd1;
      2'd1:    t = 3'd2;
      default: t = 3'd5;
    endcase
    return t;
  endfunction

endpackage

### src/event_fifo_with_coalescing_slots.sv
// Top level of the coalescing event queue: sequencer, ring memory, slots and cache.
//
// Event queue with a drop-oldest ring of QUEUE_SLOTS messages, latest-value pending
// slots for topics 1, 2 and 5 and a per-topic body cache. A push passes the push
// state, a pop the ring read and ring pop states or the slot scan (one slot compare
// per cycle through a shared 32-bit subtractor), a snapshot the snap state (one
// cached topic per cycle into the single ring write port); every mode then passes
// the done state, which loads the result. The block takes one item at a time and is
// ready again once the result register is free. The result waits in an output
// register until taken.
module event_fifo_with_coalescing_slots
  import efc_pkg::*;
#(
  parameter int unsigned QUEUE_SLOTS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // mode[1:0], topic[4:2], body[36:5], now_ms[68:37], zero fill to 72
  input  logic [71:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[2:0], msg_topic[5:3], msg_body[37:6], msg_time[69:38], msg_seq[101:70],
  // msg_snap[102], replayed[106:103], depth[111:107], dropped_total[143:112],
  // coalesced_total[175:144], next_seq[207:176]
  output logic [207:0] m_axis_tdata
);

  localparam int unsigned PtrW = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_SLOTS + 1);
  localparam int unsigned EntW = 3 + 1 + 32 + 32 + 32;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PUSH  = 7'b0000010,
    S_RD    = 7'b0000100,
    S_POPR  = 7'b0001000,
    S_SCAN  = 7'b0010000,
    S_SNAP  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // latched input
  logic [1:0]  mode_q;
  logic [2:0]  topic_q;
  logic [31:0] body_q, now_q;

  // ring control
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic [31:0] seq_q, drop_q, coal_q;

  // slots and cache
  logic [31:0] slot_body_q [SlotCount];
  logic [31:0] slot_time_q [SlotCount];
  logic [31:0] slot_seq_q  [SlotCount];
  logic [SlotCount-1:0] slot_pend_q;
  logic [31:0] cache_q [TopicCount];
  logic [TopicCount-1:0] cache_vld_q;

  // scan state
  logic [2:0] idx_q;
  logic [1:0] best_q;
  logic [3:0] repl_q;
  logic       dropflag_q;
  logic       rd_popped_q;

  // ring memory
  logic [EntW-1:0] ring_mem [QUEUE_SLOTS];
  logic [EntW-1:0] rd_data_q;
  logic            mem_we;
  logic [EntW-1:0] mem_wdata;

  // output register
  logic          ovalid_q;
  logic [207:0]  odata_q;

  assign s_axis_tready = (state_q == S_IDLE) && !ovalid_q;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;

  function automatic logic [PtrW-1:0] pnext(input logic [PtrW-1:0] p);
    return (32'(p) + 32'd1 >= QUEUE_SLOTS) ? '0 : p + PtrW'(1);
  endfunction

  logic ring_full;
  assign ring_full = (32'(cnt_q) >= QUEUE_SLOTS);

  // shared compare: is slot idx older than current best
  logic [31:0] diff;
  logic [1:0]  sidx;
  assign sidx = idx_q[1:0];
  assign diff = slot_seq_q[sidx] - slot_seq_q[best_q];

  logic [1:0] pend_cnt;
  assign pend_cnt = 2'(slot_pend_q[0]) + 2'(slot_pend_q[1]) + 2'(slot_pend_q[2]);

  // ring write data and strobe
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = {topic_q, 1'b0, body_q, now_q, seq_q};
    if (state_q == S_PUSH && slot_of(topic_q) == SlotNone) begin
      mem_we = 1'b1;
    end else if (state_q == S_SNAP && cache_vld_q[idx_q]) begin
      mem_we    = 1'b1;
      mem_wdata = {idx_q, 1'b1, cache_q[idx_q], now_q, seq_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) ring_mem[wptr_q] <= mem_wdata;
    rd_data_q <= ring_mem[rptr_q];
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
        unique case (mode_e'(s_axis_tdata[1:0]))
          MODE_PUSH: state_d = S_PUSH;
          MODE_POP:  state_d = S_RD;
          MODE_SNAP: state_d = S_SNAP;
          default:   state_d = S_DONE;
        endcase
      end
      S_PUSH: state_d = S_DONE;
      S_RD:   state_d = (cnt_q != '0) ? S_POPR : S_SCAN;
      S_POPR: state_d = S_DONE;
      S_SCAN: if (idx_q == 3'd2) state_d = S_DONE;
      S_SNAP: if (idx_q == 3'd7) state_d = S_DONE;
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && s_axis_tvalid && s_axis_tready) begin
      mode_q  <= s_axis_tdata[1:0];
      topic_q <= s_axis_tdata[4:2];
      body_q  <= s_axis_tdata[36:5];
      now_q   <= s_axis_tdata[68:37];
    end
    if (state_q == S_PUSH && slot_of(topic_q) != SlotNone) begin
      slot_body_q[slot_of(topic_q)] <= body_q;
      slot_time_q[slot_of(topic_q)] <= now_q;
    end
    if (state_q == S_PUSH && topic_q != LogTopic) cache_q[topic_q] <= body_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wptr_q      <= '0;
      rptr_q      <= '0;
      cnt_q       <= '0;
      seq_q       <= '0;
      drop_q      <= '0;
      coal_q      <= '0;
      slot_pend_q <= '0;
      cache_vld_q <= '0;
      for (int i = 0; i < SlotCount; i++) slot_seq_q[i] <= '0;
      idx_q       <= '0;
      best_q      <= SlotNone;
      repl_q      <= '0;
      dropflag_q  <= 1'b0;
      ovalid_q    <= 1'b0;
      odata_q     <= '0;
    end else begin
      state_q <= state_d;
      if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          idx_q      <= '0;
          best_q     <= SlotNone;
          repl_q     <= '0;
          dropflag_q <= 1'b0;
          if (s_axis_tvalid && s_axis_tready) odata_q <= '0;
        end
        S_PUSH: begin
          if (topic_q != LogTopic) cache_vld_q[topic_q] <= 1'b1;
          seq_q <= seq_q + 32'd1;
          if (slot_of(topic_q) != SlotNone) begin
            if (slot_pend_q[slot_of(topic_q)]) coal_q <= coal_q + 32'd1;
            slot_pend_q[slot_of(topic_q)] <= 1'b1;
            slot_seq_q[slot_of(topic_q)]  <= seq_q;
          end else begin
            wptr_q <= pnext(wptr_q);
            if (ring_full) begin
              rptr_q     <= pnext(rptr_q);
              drop_q     <= drop_q + 32'd1;
              dropflag_q <= 1'b1;
            end else begin
              cnt_q <= cnt_q + CntW'(1);
            end
          end
        end
        S_RD: ;
        S_POPR: begin
          odata_q[5:3]    <= rd_data_q[EntW-1 -: 3];
          odata_q[102]    <= rd_data_q[96];
          odata_q[37:6]   <= rd_data_q[95:64];
          odata_q[69:38]  <= rd_data_q[63:32];
          odata_q[101:70] <= rd_data_q[31:0];
          rptr_q <= pnext(rptr_q);
          cnt_q  <= cnt_q - CntW'(1);
        end
        S_SCAN: begin
          logic take;
          take = slot_pend_q[sidx] && (best_q == SlotNone || diff[31]);
          if (idx_q == 3'd2) begin
            logic [1:0] b;
            b = take ? sidx : best_q;
            if (b != SlotNone) begin
              odata_q[5:3]    <= slot_topic(b);
              odata_q[37:6]   <= slot_body_q[b];
              odata_q[69:38]  <= slot_time_q[b];
              odata_q[101:70] <= slot_seq_q[b];
              slot_pend_q[b]  <= 1'b0;
            end
            best_q <= b;
          end else begin
            if (take) best_q <= sidx;
            idx_q <= idx_q + 3'd1;
          end
        end
        S_SNAP: begin
          if (cache_vld_q[idx_q]) begin
            seq_q  <= seq_q + 32'd1;
            wptr_q <= pnext(wptr_q);
            repl_q <= repl_q + 4'd1;
            if (ring_full) begin
              rptr_q <= pnext(rptr_q);
              drop_q <= drop_q + 32'd1;
            end else begin
              cnt_q <= cnt_q + CntW'(1);
            end
          end
          idx_q <= idx_q + 3'd1;
        end
        S_DONE: begin
          status_e st;
          unique case (mode_e'(mode_q))
            MODE_PUSH: st = dropflag_q ? ST_PUSH_DROP : ST_PUSH_CLEAN;
            MODE_POP:  st = (odata_q[5:3] != 3'd0 || best_q != SlotNone ||
                             rd_popped_q) ? ST_POPPED : ST_EMPTY;
            MODE_SNAP: st = ST_SNAP_DONE;
            default:   st = ST_EMPTY;
          endcase
          odata_q[2:0]     <= st;
          odata_q[106:103] <= (mode_q == MODE_SNAP) ? repl_q : 4'd0;
          odata_q[111:107] <= 5'(32'(cnt_q) + 32'(pend_cnt));
          odata_q[143:112] <= drop_q;
          odata_q[175:144] <= coal_q;
          odata_q[207:176] <= seq_q;
          ovalid_q         <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // mark a pop served from the ring
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rd_popped_q <= 1'b0;
    else if (state_q == S_IDLE) rd_popped_q <= 1'b0;
    else if (state_q == S_POPR) rd_popped_q <= 1'b1;
  end

endmodule
